// ===== hdl/biq_pkg.sv =====
package biq_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int COEF_BITS          = 24;
    localparam int DEF_STATE_BITS     = 32;
    localparam int DEF_COEF_FRAC_BITS = 20;

    // state words are split into 24-bit chunks for the shared multiplier
    localparam int CHUNK_BITS = 24;
    localparam int MUL_BITS   = CHUNK_BITS + 1;
    localparam int STEP_BITS  = 4;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

    localparam logic [COEF_BITS-1:0] COEF_B0_RESET = 24'd1048576;

    // multiply schedule: coefficient, state word, chunk
    localparam logic [STEP_BITS-1:0] STEP_A1_W1_LO = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_A1_W1_HI = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_A2_W2_LO = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_A2_W2_HI = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_B0_W_LO  = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_B0_W_HI  = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_B1_W1_LO = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_B1_W1_HI = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_B2_W2_LO = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_B2_W2_HI = 4'd9;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          restart;
        logic                          block_end;
    } biq_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          block_end_out;
        logic                          clipped;
    } biq_out_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } biq_coef_t;

    typedef struct packed {
        logic                 start;
        logic                 mac_en;
        logic [STEP_BITS-1:0] step;
        logic                 fin_w;
        logic                 fin_y;
    } biq_cmd_t;

    function automatic logic signed [MUL_BITS-1:0] coef_ext(logic signed [COEF_BITS-1:0] c);
        coef_ext = {c[COEF_BITS-1], c};
    endfunction

endpackage

// ===== hdl/biq_cfg.sv =====
module biq_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
    input  logic [biq_pkg::COEF_BITS-1:0]       cfg_data,
    output biq_pkg::biq_coef_t                  coef
);
    import biq_pkg::*;

    biq_coef_t coef_reg;
    biq_coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_B0:  coef_next.b0 = cfg_data;
                REG_B1:  coef_next.b1 = cfg_data;
                REG_B2:  coef_next.b2 = cfg_data;
                REG_A1:  coef_next.a1 = cfg_data;
                REG_A2:  coef_next.a2 = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ===== hdl/biq_ctl.sv =====
module biq_ctl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              smp_valid,
    output logic              smp_stall,
    output logic              res_valid,
    input  logic              res_stall,
    output biq_pkg::biq_cmd_t cmd
);
    import biq_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAC_W = 7'b0000010,
        ST_ACC_W = 7'b0000100,
        ST_FIN_W = 7'b0001000,
        ST_MAC_Y = 7'b0010000,
        ST_ACC_Y = 7'b0100000,
        ST_FIN_Y = 7'b1000000
    } biq_state_t;

    biq_state_t           state_reg;
    biq_state_t           state_next;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [STEP_BITS-1:0] cnt_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp_valid)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = STEP_A1_W1_LO;
                    state_next = ST_MAC_W;
                end
            end
            ST_MAC_W:
            begin
                cmd.mac_en = 1'b1;
                cmd.step   = cnt_reg;
                if (cnt_reg == STEP_A2_W2_HI)
                    state_next = ST_ACC_W;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ACC_W:
            begin
                state_next = ST_FIN_W;
            end
            ST_FIN_W:
            begin
                cmd.fin_w  = 1'b1;
                cnt_next   = STEP_B0_W_LO;
                state_next = ST_MAC_Y;
            end
            ST_MAC_Y:
            begin
                cmd.mac_en = 1'b1;
                cmd.step   = cnt_reg;
                if (cnt_reg == STEP_B2_W2_HI)
                    state_next = ST_ACC_Y;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_ACC_Y:
            begin
                state_next = ST_FIN_Y;
            end
            ST_FIN_Y:
            begin
                // hold until the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    cmd.fin_y      = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign smp_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;

endmodule

// ===== hdl/biq_dp.sv =====
module biq_dp #(
    parameter int STATE_BITS     = biq_pkg::DEF_STATE_BITS,
    parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  biq_pkg::biq_cmd_t  cmd,
    input  biq_pkg::biq_in_t   smp,
    input  biq_pkg::biq_coef_t coef,
    output biq_pkg::biq_out_t  res
);
    import biq_pkg::*;

    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int EXT_BITS  = 2 * CHUNK_BITS + 1;
    localparam int ACC_W     = (((COEF_BITS + STATE_BITS) > (SAMPLE_BITS + COEF_FRAC_BITS)) ?
                                (COEF_BITS + STATE_BITS) : (SAMPLE_BITS + COEF_FRAC_BITS)) + 4;

    localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ST_MAX  = {{(ACC_W-STATE_BITS+1){1'b0}},
                                                   {(STATE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN  = ~ST_MAX;
    localparam logic signed [ACC_W-1:0] SMP_MAX = {{(ACC_W-SAMPLE_BITS+1){1'b0}},
                                                   {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;

    logic signed [STATE_BITS-1:0] w1_reg, w1_next;
    logic signed [STATE_BITS-1:0] w2_reg, w2_next;
    logic signed [STATE_BITS-1:0] w_reg, w_next;
    logic signed [PROD_BITS-1:0]  prod_reg, prod_next;
    logic                         prod_hi_reg, prod_hi_next;
    logic                         prod_vld_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic                         be_reg, be_next;
    logic                         clip_reg, clip_next;
    biq_out_t                     res_reg, res_next;

    logic signed [MUL_BITS-1:0]   mc;
    logic signed [MUL_BITS-1:0]   md;
    logic signed [STATE_BITS-1:0] v;
    logic [EXT_BITS-1:0]          v_ext;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      addend;
    logic signed [ACC_W-1:0]      bias;
    logic signed [ACC_W-1:0]      q;
    logic                         q_hi_st, q_lo_st, q_hi_smp, q_lo_smp;

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (cmd.step)
            STEP_A1_W1_LO: begin mc = -coef_ext(coef.a1); v = w1_reg; prod_hi_next = 1'b0; end
            STEP_A1_W1_HI: begin mc = -coef_ext(coef.a1); v = w1_reg; prod_hi_next = 1'b1; end
            STEP_A2_W2_LO: begin mc = -coef_ext(coef.a2); v = w2_reg; prod_hi_next = 1'b0; end
            STEP_A2_W2_HI: begin mc = -coef_ext(coef.a2); v = w2_reg; prod_hi_next = 1'b1; end
            STEP_B0_W_LO:  begin mc = coef_ext(coef.b0);  v = w_reg;  prod_hi_next = 1'b0; end
            STEP_B0_W_HI:  begin mc = coef_ext(coef.b0);  v = w_reg;  prod_hi_next = 1'b1; end
            STEP_B1_W1_LO: begin mc = coef_ext(coef.b1);  v = w1_reg; prod_hi_next = 1'b0; end
            STEP_B1_W1_HI: begin mc = coef_ext(coef.b1);  v = w1_reg; prod_hi_next = 1'b1; end
            STEP_B2_W2_LO: begin mc = coef_ext(coef.b2);  v = w2_reg; prod_hi_next = 1'b0; end
            STEP_B2_W2_HI: begin mc = coef_ext(coef.b2);  v = w2_reg; prod_hi_next = 1'b1; end
            default:       begin mc = '0;                 v = '0;     prod_hi_next = 1'b0; end
        endcase
        v_ext = {{(EXT_BITS-STATE_BITS){v[STATE_BITS-1]}}, v};
        // low chunk unsigned, high chunk signed
        if (prod_hi_next)
            md = $signed(v_ext[EXT_BITS-1:CHUNK_BITS]);
        else
            md = $signed({1'b0, v_ext[CHUNK_BITS-1:0]});
        prod_next = mc * md;
    end

    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
        addend   = prod_hi_reg ? (prod_ext <<< CHUNK_BITS) : prod_ext;
        bias     = ({{(ACC_W-SAMPLE_BITS){smp.sample_in[SAMPLE_BITS-1]}}, smp.sample_in}
                    <<< COEF_FRAC_BITS) + ROUND;

        priority if (cmd.start)
            acc_next = bias;
        else if (cmd.fin_w)
            acc_next = ROUND;
        else if (prod_vld_reg)
            acc_next = acc_reg + addend;
        else
            acc_next = acc_reg;

        q        = acc_reg >>> COEF_FRAC_BITS;
        q_hi_st  = (q > ST_MAX);
        q_lo_st  = (q < ST_MIN);
        q_hi_smp = (q > SMP_MAX);
        q_lo_smp = (q < SMP_MIN);

        w_next    = w_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        be_next   = be_reg;
        clip_next = clip_reg;
        res_next  = res_reg;

        if (cmd.start)
        begin
            be_next   = smp.block_end;
            clip_next = 1'b0;
            if (smp.restart)
            begin
                w1_next = '0;
                w2_next = '0;
            end
        end

        if (cmd.fin_w)
        begin
            priority if (q_hi_st)
                w_next = ST_MAX[STATE_BITS-1:0];
            else if (q_lo_st)
                w_next = ST_MIN[STATE_BITS-1:0];
            else
                w_next = q[STATE_BITS-1:0];
            clip_next = clip_reg | q_hi_st | q_lo_st;
        end

        if (cmd.fin_y)
        begin
            priority if (q_hi_smp)
                res_next.sample_out = SMP_MAX[SAMPLE_BITS-1:0];
            else if (q_lo_smp)
                res_next.sample_out = SMP_MIN[SAMPLE_BITS-1:0];
            else
                res_next.sample_out = q[SAMPLE_BITS-1:0];
            res_next.block_end_out = be_reg;
            res_next.clipped       = clip_reg | q_hi_smp | q_lo_smp;
            w2_next = w1_reg;
            w1_next = w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg       <= '0;
            w2_reg       <= '0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            w1_reg       <= w1_next;
            w2_reg       <= w2_next;
            prod_vld_reg <= cmd.mac_en;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg       <= w_next;
        prod_reg    <= prod_next;
        prod_hi_reg <= prod_hi_next;
        acc_reg     <= acc_next;
        be_reg      <= be_next;
        clip_reg    <= clip_next;
        res_reg     <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== hdl/biquad_iir_filter.sv =====
// A single 25x25 multiplier forms ten partial products per sample (state words split
// into 24-bit chunks), so a new sample is not accepted until the current one is finished.
// A result may wait in the output register while the next sample is computed.
// Reset (async, active low): b0 = 1.0, other coefficients 0, delay line cleared,
// no transaction pending.
module biquad_iir_filter #(
    parameter int STATE_BITS     = biq_pkg::DEF_STATE_BITS,
    parameter int COEF_FRAC_BITS = biq_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             smp_valid,
    output logic                             smp_stall,
    input  biq_pkg::biq_in_t                 smp,
    output logic                             res_valid,
    input  logic                             res_stall,
    output biq_pkg::biq_out_t                res,
    input  logic                             cfg_we,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0] cfg_idx,
    input  logic [biq_pkg::COEF_BITS-1:0]    cfg_data
);
    import biq_pkg::*;

    biq_cmd_t  cmd;
    biq_coef_t coef;

    biq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .coef     (coef)
    );

    biq_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .cmd       (cmd)
    );

    biq_dp #(
        .STATE_BITS     (STATE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .smp   (smp),
        .coef  (coef),
        .res   (res)
    );

endmodule

// ===== hdl/biq_chk.sv =====
module biq_chk (
    input logic              clk,
    input logic              rst_n,
    input logic              smp_valid,
    input logic              smp_stall,
    input logic              res_valid,
    input logic              res_stall,
    input biq_pkg::biq_out_t res
);
    import biq_pkg::*;

    logic       acc_in;
    logic       acc_out;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign acc_in  = smp_valid && !smp_stall;
    assign acc_out = res_valid && !res_stall;

    always_comb
    begin
        pend_next = pend_reg + {1'b0, acc_in} - {1'b0, acc_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        acc_in |=> smp_stall)
        else $error("input taken while a sample is in flight");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc_in |=> !$rose(res_valid))
        else $error("result appeared right after a transaction was taken");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pend_reg != 2'd0))
        else $error("result without a pending input transaction");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("more than two transactions outstanding");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind biquad_iir_filter biq_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
